@@ rtl/mpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// mpwm_pkg
// shared types and constants for the multichannel pwm generator
// ----------------------------------------------------------------------------
package mpwm_pkg;

	localparam int CHANNELS   = 32;
	localparam int CH_W       = 5;
	localparam int COUNT_W    = 17;
	localparam int PER_W      = 16;
	localparam int SRC_W      = 24;
	localparam int QDEPTH     = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX  = 17'h1FFFF;
	localparam logic [PER_W-1:0]   PERIOD_MAX = 16'hFFFF;
	localparam logic [13:0]        DUTY_FULL  = 14'd10000;
	localparam logic [SRC_W-1:0]   SRC_RESET  = 24'd200000;

	// ceil(2^36 / 625): exact floor divide by 625 for 26-bit dividends
	localparam logic [26:0]        DUTY_RECIP = 27'd109951163;

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_DUTY  = 3'd1,
		CMD_FREQ  = 3'd2,
		CMD_POL   = 3'd3,
		CMD_EN    = 3'd4,
		CMD_DIS   = 3'd5,
		CMD_RST   = 3'd6,
		CMD_INIT  = 3'd7
	} cmd_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [4:0]  channel;
		logic [15:0] num_clk;
		logic [13:0] duty;
		logic [15:0] frequency;
		logic        polarity;
	} in_item_t;

	typedef struct packed {
		logic [31:0] pin_levels;
		logic [31:0] changed_mask;
	} out_item_t;

	// classified work handed from front to back
	typedef struct packed {
		cmd_t        cmd;
		logic [4:0]  channel;
		logic [15:0] num_clk;
		logic [15:0] per;      // derived period (freq / init)
		logic [13:0] duty;     // clamped duty
		logic        polarity;
	} job_t;

endpackage

@@ rtl/mpwm_front.sv @@
// ----------------------------------------------------------------------------
// mpwm_front
// accepts items, derives the period by a restoring divider, clamps duty
// ----------------------------------------------------------------------------
module mpwm_front import mpwm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [SRC_W-1:0] src_hz,
	input  in_item_t        in_item,
	input  logic            in_push,
	output logic            in_full,
	output job_t            job,
	output logic            job_valid,
	input  logic            job_ready
);

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_OUT} fstate_t;

	fstate_t          state_q;
	job_t             job_q;
	logic [SRC_W-1:0] quo_q;
	logic [SRC_W-1:0] rem_q;
	logic [15:0]      den_q;
	logic [4:0]       step_q;
	logic [SRC_W:0]   trial;
	logic [SRC_W-1:0] shifted;

	assign in_full   = (state_q != F_IDLE);
	assign job       = job_q;
	assign job_valid = (state_q == F_OUT);

	// one quotient bit per cycle
	assign shifted = {rem_q[SRC_W-2:0], quo_q[SRC_W-1]};
	assign trial   = {1'b0, shifted} - {{(SRC_W-15){1'b0}}, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: if (in_push) begin
					job_q.cmd      <= cmd_t'(in_item.cmd);
					job_q.channel  <= in_item.channel;
					job_q.num_clk  <= in_item.num_clk;
					job_q.duty     <= (in_item.duty > DUTY_FULL) ? DUTY_FULL : in_item.duty;
					job_q.polarity <= in_item.polarity;
					job_q.per      <= PERIOD_MAX;
					den_q          <= in_item.frequency;
					quo_q          <= src_hz;
					rem_q          <= '0;
					step_q         <= '0;
					if ((cmd_t'(in_item.cmd) == CMD_FREQ || cmd_t'(in_item.cmd) == CMD_INIT)
						&& in_item.frequency != '0)
						state_q <= F_DIV;
					else
						state_q <= F_OUT;
				end
				F_DIV: begin
					if (!trial[SRC_W]) begin
						rem_q <= trial[SRC_W-1:0];
						quo_q <= {quo_q[SRC_W-2:0], 1'b1};
					end else begin
						rem_q <= shifted;
						quo_q <= {quo_q[SRC_W-2:0], 1'b0};
					end
					step_q <= step_q + 5'd1;
					if (step_q == 5'(SRC_W)) begin
						job_q.per <= (quo_q[SRC_W-1:PER_W] != '0) ? PERIOD_MAX : quo_q[PER_W-1:0];
						state_q   <= F_OUT;
					end
				end
				F_OUT: if (job_ready) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// the final step above is a spare cycle; guard the quotient shift
	// (step SRC_W captures the finished quotient before it shifts again)

endmodule

@@ rtl/mpwm_queue.sv @@
// ----------------------------------------------------------------------------
// mpwm_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module mpwm_queue import mpwm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t wr_job,
	input  logic wr_valid,
	output logic wr_ready,
	output job_t rd_job,
	output logic rd_valid,
	input  logic rd_ready
);

	job_t       mem_q [QDEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr_en, rd_en;

	assign wr_ready = (cnt_q != 2'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_job   = mem_q[rp_q];
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_job;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

@@ rtl/mpwm_back.sv @@
// ----------------------------------------------------------------------------
// mpwm_back
// channel bank: for tick and init-all walks one channel per cycle, then posts the result beat
// ----------------------------------------------------------------------------
module mpwm_back import mpwm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      job,
	input  logic      job_valid,
	output logic      job_ready,
	output out_item_t res,
	output logic      res_empty,
	input  logic      res_pop
);

	typedef enum logic [1:0] {B_IDLE, B_MUL, B_WALK, B_DONE} bstate_t;

	bstate_t              state_q;
	job_t                 cur_q;
	logic [CH_W-1:0]      idx_q;
	logic [COUNT_W-1:0]   count_q [CHANNELS];
	logic [PER_W-1:0]     period_q [CHANNELS];
	logic [PER_W-1:0]     compare_q [CHANNELS];
	logic [CHANNELS-1:0]  en_q, idle_q, out_q, before_q;
	logic [29:0]          prod_q;
	logic [52:0]          dscale;
	logic [PER_W-1:0]     cmp_new;
	out_item_t            res_q;
	logic                 res_full_q;
	logic                 res_load;
	logic [PER_W-1:0]     mul_per;
	logic [COUNT_W:0]     sum;
	logic [COUNT_W-1:0]   nsat;
	logic [CHANNELS-1:0]  after_lv;

	assign res       = res_q;
	assign res_empty = !res_full_q;
	assign job_ready = (state_q == B_IDLE);
	assign res_load  = (state_q == B_DONE) && (!res_full_q || res_pop);

	// duty scale: product over 10000, as a divide by 16 then by 625
	assign mul_per = (cur_q.cmd == CMD_INIT) ? cur_q.per : period_q[cur_q.channel];
	assign dscale  = 53'(prod_q[29:4]) * 53'(DUTY_RECIP);
	assign cmp_new = dscale[51:36];

	// per-channel tick arithmetic
	assign sum  = {1'b0, count_q[idx_q]} + {{(COUNT_W-15){1'b0}}, cur_q.num_clk};
	assign nsat = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];

	// levels after this command
	always_comb begin
		after_lv = out_q;
		unique case (cur_q.cmd) inside
			CMD_POL: after_lv[cur_q.channel] = cur_q.polarity;
			CMD_DIS, CMD_RST: after_lv[cur_q.channel] = idle_q[cur_q.channel];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			res_full_q <= 1'b0;
			res_q      <= '0;
			idx_q      <= '0;
			en_q       <= '0;
			idle_q     <= '0;
			out_q      <= '0;
			before_q   <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				count_q[i]   <= '0;
				period_q[i]  <= '0;
				compare_q[i] <= '0;
			end
		end else begin
			if (res_pop && res_full_q && !res_load) res_full_q <= 1'b0;
			unique case (state_q)
				B_IDLE: if (job_valid) begin
					cur_q    <= job;
					before_q <= out_q;
					idx_q    <= '0;
					state_q  <= B_MUL;
				end
				B_MUL: begin
					prod_q <= 30'(mul_per) * 30'(cur_q.duty);
					if (cur_q.cmd == CMD_TICK || cur_q.cmd == CMD_INIT) state_q <= B_WALK;
					else state_q <= B_DONE;
					if (cur_q.cmd == CMD_INIT) begin
						en_q   <= '0;
						idle_q <= {CHANNELS{cur_q.polarity}};
						out_q  <= {CHANNELS{cur_q.polarity}};
					end
				end
				B_WALK: begin
					if (cur_q.cmd == CMD_INIT) begin
						count_q[idx_q]   <= '0;
						period_q[idx_q]  <= cur_q.per;
						compare_q[idx_q] <= cmp_new;
					end else if (en_q[idx_q]) begin
						if (count_q[idx_q] >= {1'b0, compare_q[idx_q]}) begin
							if (nsat >= {1'b0, period_q[idx_q]}) begin
								out_q[idx_q]   <= ~out_q[idx_q];
								count_q[idx_q] <= '0;
							end else count_q[idx_q] <= nsat;
						end else begin
							count_q[idx_q] <= nsat;
							if (nsat >= {1'b0, compare_q[idx_q]}) out_q[idx_q] <= ~out_q[idx_q];
						end
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == CH_W'(CHANNELS-1)) state_q <= B_DONE;
				end
				B_DONE: if (res_load) begin
					unique case (cur_q.cmd)
						CMD_DUTY: compare_q[cur_q.channel] <= cmp_new;
						CMD_FREQ: period_q[cur_q.channel]  <= cur_q.per;
						CMD_POL: begin
							idle_q[cur_q.channel]  <= cur_q.polarity;
							out_q[cur_q.channel]   <= cur_q.polarity;
							count_q[cur_q.channel] <= '0;
						end
						CMD_EN: en_q[cur_q.channel] <= 1'b1;
						CMD_DIS: begin
							en_q[cur_q.channel]    <= 1'b0;
							out_q[cur_q.channel]   <= idle_q[cur_q.channel];
							count_q[cur_q.channel] <= '0;
						end
						CMD_RST: begin
							out_q[cur_q.channel]   <= idle_q[cur_q.channel];
							count_q[cur_q.channel] <= '0;
						end
						default: ;
					endcase
					// result beat: levels after this command and the changed bits
					res_q.pin_levels   <= after_lv;
					res_q.changed_mask <= after_lv ^ before_q;
					res_full_q         <= 1'b1;
					state_q            <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/multichannel_pwm_generator_core.sv @@
// ----------------------------------------------------------------------------
// multichannel_pwm_generator_core
// 32-channel pwm bank driven by a command queue
// ----------------------------------------------------------------------------
// items enter on push/full and results leave on empty/pop; one result
// beat per item. the front takes an item, runs a restoring divide for
// set-frequency and init-all, and queues a job (two deep). the back
// walks the 32 channel entries one per cycle for tick and init-all;
// other commands skip the walk. the walk over the channel bank sets the
// sustained tick rate. the back holds a finished beat in an output
// register and stalls only when that register is still full; the front
// keeps accepting until the queue fills, but holds full while dividing
// or waiting to hand over a job. reset clears every channel to disabled
// with zero state and source_clock_hz to 200000. the apb register at
// address 0 holds source_clock_hz; the user must write it only while
// the block is idle, the block itself does not enforce this.
// ----------------------------------------------------------------------------
module multichannel_pwm_generator_core import mpwm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  in_item_t    in_item,
	input  logic        push,
	output logic        full,
	output out_item_t   out_item,
	output logic        empty,
	input  logic        pop
);

	logic [SRC_W-1:0] src_q;
	job_t fj, qj;
	logic fv, fr, qv, qr;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? {8'd0, src_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) src_q <= SRC_RESET;
		else if (psel && penable && pwrite && paddr == 1'b0) src_q <= pwdata[SRC_W-1:0];
	end

	mpwm_front u_front (.clk, .arst_n, .src_hz(src_q), .in_item, .in_push(push),
		.in_full(full), .job(fj), .job_valid(fv), .job_ready(fr));

	mpwm_queue u_queue (.clk, .arst_n, .wr_job(fj), .wr_valid(fv), .wr_ready(fr),
		.rd_job(qj), .rd_valid(qv), .rd_ready(qr));

	mpwm_back u_back (.clk, .arst_n, .job(qj), .job_valid(qv), .job_ready(qr),
		.res(out_item), .res_empty(empty), .res_pop(pop));

endmodule
